### sv/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants of the multichannel PWM generator.
// ----------------------------------------------------------------------------
package mpwm_pkg;

    localparam int DEF_CHANNELS = 8;
    localparam int DEF_PERIOD   = 100;

    localparam int ACTION_W   = 3;
    localparam int CHANNEL_W  = 3;
    localparam int DUTY_W     = 7;
    localparam int PRESCALE_W = 16;
    localparam int LEVELS_W   = 8;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd899;
    localparam logic [DUTY_W-1:0]     DUTY_FULL      = 7'd100;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 3'd0,
        ACT_SET     = 3'd1,
        ACT_FORCE_1 = 3'd2,
        ACT_FORCE_0 = 3'd3,
        ACT_NORMAL  = 3'd4,
        ACT_CLAIM   = 3'd5,
        ACT_RELEASE = 3'd6
    } action_t;

    typedef struct packed {
        logic step;
        logic wrap;
    } tb_event_t;

    typedef struct packed {
        logic                 ok;
        logic [CHANNEL_W-1:0] index;
    } claim_t;

endpackage

### sv/mpwm_timebase.sv
// ----------------------------------------------------------------------------
// mpwm_timebase
// Prescaler and period counter; steps the counter and flags the wrap.
// ----------------------------------------------------------------------------
module mpwm_timebase #(
    parameter int PERIOD = mpwm_pkg::DEF_PERIOD,
    parameter int CNT_W  = $clog2(PERIOD)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic [mpwm_pkg::PRESCALE_W-1:0] prescale_divide,
    output mpwm_pkg::tb_event_t             tb_event,
    output logic [CNT_W-1:0]                count_next
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(PERIOD - 1);

    logic [mpwm_pkg::PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [CNT_W-1:0]                count_reg, count_upd;
    logic                            limit;

    always_comb begin
        limit         = !(prescale_reg < prescale_divide);
        tb_event.step = advance && limit;
        tb_event.wrap = advance && limit && (count_reg == LAST);
        count_upd     = (count_reg == LAST) ? '0 : count_reg + CNT_W'(1);
        count_next    = count_upd;
        prescale_next = prescale_reg;
        if (advance) begin
            prescale_next = limit ? '0 : prescale_reg + mpwm_pkg::PRESCALE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            count_reg    <= '0;
        end else begin
            prescale_reg <= prescale_next;
            if (tb_event.step) begin
                count_reg <= count_upd;
            end
        end
    end

endmodule

### sv/mpwm_channels.sv
// ----------------------------------------------------------------------------
// mpwm_channels
// Per-channel state, command decode, claim search and pin drive.
// ----------------------------------------------------------------------------
module mpwm_channels #(
    parameter int CHANNELS = mpwm_pkg::DEF_CHANNELS,
    parameter int PERIOD   = mpwm_pkg::DEF_PERIOD,
    parameter int CNT_W    = $clog2(PERIOD)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  mpwm_pkg::action_t              action,
    input  logic [mpwm_pkg::CHANNEL_W-1:0] channel,
    input  logic [mpwm_pkg::DUTY_W-1:0]    duty,
    input  logic                           invert_request,
    input  mpwm_pkg::tb_event_t            tb_event,
    input  logic [CNT_W-1:0]               count_next,
    output logic [mpwm_pkg::LEVELS_W-1:0]  pin_levels,
    output mpwm_pkg::claim_t               claim
);

    // duty * PERIOD / 100 as a multiply by a scaled reciprocal
    localparam int          RECIP_SHIFT = 24;
    localparam longint      RECIP       = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
    localparam longint      MULT        = RECIP * PERIOD;
    localparam int          MULT_W      = $clog2(MULT + 1);
    localparam int          PROD_W      = mpwm_pkg::DUTY_W + MULT_W;
    localparam logic [PROD_W-1:0] MULT_C = PROD_W'(MULT);

    logic [CNT_W-1:0]    cmp_val_reg  [CHANNELS];
    logic [CNT_W-1:0]    cmp_val_next [CHANNELS];
    logic [CHANNELS-1:0] cmp_en_reg, cmp_en_next;
    logic [CHANNELS-1:0] blanked_reg, blanked_next;
    logic [CHANNELS-1:0] in_use_reg, in_use_next;
    logic [CHANNELS-1:0] inverted_reg, inverted_next;
    logic [CHANNELS-1:0] pin_reg, pin_next;
    logic [CHANNELS-1:0] free, lowest;
    logic [PROD_W-1:0]   product;
    logic [CNT_W-1:0]    duty_cmp;

    always_comb begin
        logic sel;
        logic live;
        product  = PROD_W'(duty) * MULT_C;
        duty_cmp = CNT_W'(product >> RECIP_SHIFT);
        free     = ~in_use_reg;
        lowest   = free & (~free + CHANNELS'(1));

        cmp_val_next  = cmp_val_reg;
        cmp_en_next   = cmp_en_reg;
        blanked_next  = blanked_reg;
        in_use_next   = in_use_reg;
        inverted_next = inverted_reg;
        pin_next      = pin_reg;
        claim.ok      = 1'b0;
        claim.index   = '0;

        for (int i = 0; i < CHANNELS; i++) begin
            sel  = (i < 8) && (channel == mpwm_pkg::CHANNEL_W'(i));
            live = sel && in_use_reg[i];
            if (fire) begin
                unique case (action)
                    mpwm_pkg::ACT_TICK: begin
                        if (tb_event.step && in_use_reg[i] && !blanked_reg[i]) begin
                            if (cmp_en_reg[i] && (cmp_val_reg[i] == count_next)) begin
                                pin_next[i] = inverted_reg[i];
                            end else if (tb_event.wrap) begin
                                pin_next[i] = !inverted_reg[i];
                            end
                        end
                    end
                    mpwm_pkg::ACT_SET: begin
                        if (live && (duty <= mpwm_pkg::DUTY_FULL)) begin
                            if (duty == mpwm_pkg::DUTY_FULL) begin
                                cmp_en_next[i] = 1'b0;
                            end else begin
                                cmp_val_next[i] = duty_cmp;
                                cmp_en_next[i]  = 1'b1;
                            end
                            blanked_next[i] = 1'b0;
                        end
                    end
                    mpwm_pkg::ACT_FORCE_1, mpwm_pkg::ACT_FORCE_0: begin
                        if (live) begin
                            blanked_next[i] = 1'b1;
                            cmp_en_next[i]  = 1'b0;
                            pin_next[i]     = (action == mpwm_pkg::ACT_FORCE_1) ?
                                              !inverted_reg[i] : inverted_reg[i];
                        end
                    end
                    mpwm_pkg::ACT_NORMAL: begin
                        if (live) begin
                            blanked_next[i] = 1'b0;
                            cmp_en_next[i]  = 1'b1;
                        end
                    end
                    mpwm_pkg::ACT_CLAIM: begin
                        if (lowest[i]) begin
                            in_use_next[i]   = 1'b1;
                            inverted_next[i] = invert_request;
                            cmp_en_next[i]   = 1'b1;
                        end
                    end
                    mpwm_pkg::ACT_RELEASE: begin
                        if (live) begin
                            in_use_next[i] = 1'b0;
                            cmp_en_next[i] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if ((action == mpwm_pkg::ACT_CLAIM) && lowest[i]) begin
                claim.ok    = 1'b1;
                claim.index = claim.index | mpwm_pkg::CHANNEL_W'(i);
            end
        end

        pin_levels = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i < mpwm_pkg::LEVELS_W) begin
                pin_levels[i % mpwm_pkg::LEVELS_W] = pin_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                cmp_val_reg[i] <= '0;
            end
            cmp_en_reg   <= '0;
            blanked_reg  <= '0;
            in_use_reg   <= '0;
            inverted_reg <= '0;
            pin_reg      <= '0;
        end else begin
            cmp_val_reg  <= cmp_val_next;
            cmp_en_reg   <= cmp_en_next;
            blanked_reg  <= blanked_next;
            in_use_reg   <= in_use_next;
            inverted_reg <= inverted_next;
            pin_reg      <= pin_next;
        end
    end

endmodule

### sv/multichannel_pwm_generator.sv
// A command or tick is taken at every clock at which the slave side shows
// tvalid and the input stage is empty or passes its item on in the same
// cycle. Its result (pin levels after the command, plus the claim outcome)
// is registered in the result stage, shown on the master side, as the input
// stage passes it on. With m_tready held high, one transfer per cycle is
// sustained; the channel state and the prescaler, registered as each item
// passes, are read directly by the next item. Each tick advances the
// prescaler; every prescale_divide+1 ticks the period counter steps.
// ----------------------------------------------------------------------------
// multichannel_pwm_generator
// Top level: input stage, timebase, channel bank and result stage.
// ----------------------------------------------------------------------------
module multichannel_pwm_generator #(
    parameter int CHANNELS = mpwm_pkg::DEF_CHANNELS,
    parameter int PERIOD   = mpwm_pkg::DEF_PERIOD
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // channel, duty, invert_request
    input  logic [mpwm_pkg::ACTION_W-1:0]   s_tuser,  // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // pin_levels, claim_ok, claimed_channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mpwm_pkg::PRESCALE_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(PERIOD);

    logic                            in_valid_reg;
    mpwm_pkg::action_t               in_action_reg;
    logic [mpwm_pkg::CHANNEL_W-1:0]  in_channel_reg;
    logic [mpwm_pkg::DUTY_W-1:0]     in_duty_reg;
    logic                            in_inv_reg;
    logic                            out_valid_reg;
    logic [15:0]                     out_data_reg;
    logic [mpwm_pkg::PRESCALE_W-1:0] prescale_divide_reg;

    logic                            fire, s_accept;
    mpwm_pkg::tb_event_t             tb_event;
    logic [CNT_W-1:0]                count_next;
    logic [mpwm_pkg::LEVELS_W-1:0]   pin_levels;
    mpwm_pkg::claim_t                claim;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    mpwm_timebase #(
        .PERIOD (PERIOD),
        .CNT_W  (CNT_W)
    ) u_timebase (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (fire && (in_action_reg == mpwm_pkg::ACT_TICK)),
        .prescale_divide (prescale_divide_reg),
        .tb_event        (tb_event),
        .count_next      (count_next)
    );

    mpwm_channels #(
        .CHANNELS (CHANNELS),
        .PERIOD   (PERIOD),
        .CNT_W    (CNT_W)
    ) u_channels (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .action         (in_action_reg),
        .channel        (in_channel_reg),
        .duty           (in_duty_reg),
        .invert_request (in_inv_reg),
        .tb_event       (tb_event),
        .count_next     (count_next),
        .pin_levels     (pin_levels),
        .claim          (claim)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            prescale_divide_reg <= mpwm_pkg::PRESCALE_RESET;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                prescale_divide_reg <= cfg_data;
            end
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg  <= mpwm_pkg::action_t'(s_tuser);
            in_channel_reg <= s_tdata[2:0];
            in_duty_reg    <= s_tdata[9:3];
            in_inv_reg     <= s_tdata[10];
        end
        if (fire) begin
            out_data_reg <= {4'd0, claim.index, claim.ok, pin_levels};
        end
    end

endmodule
